// ----- rtl/gbn_pkg.sv -----
package gbn_pkg;

  localparam int unsigned PAYLOAD_BYTES = 20;
  localparam int unsigned PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int unsigned MAX_WINDOW    = 64;
  localparam int unsigned CNT_W         = 7;
  localparam int unsigned SEQ_W         = 16;
  localparam int unsigned CHK_W         = 32;
  // 20 signed bytes sum into -2560..2540
  localparam int unsigned SUM_W         = 13;
  localparam int unsigned GRP_BYTES     = 4;
  localparam int unsigned GRP_NUM       = PAYLOAD_BYTES / GRP_BYTES;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = 2;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;

  localparam logic [CNT_W-1:0] WINDOW_RESET  = 7'd8;
  localparam logic [15:0]      TIMEOUT_RESET = 16'd40;

  typedef enum logic [1:0] {
    REQ_MSG  = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_TICK = 2'd2
  } req_kind_e;

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_DROP = 1'b1
  } cmd_kind_e;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_EXEC = 2'd1,
    F_FILL = 2'd2
  } front_state_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [63:0]        payload_low;
    logic [63:0]        payload_middle;
    logic [31:0]        payload_high;
    logic [15:0]        ack_number;
    logic [15:0]        ack_sequence;
    logic signed [31:0] ack_check;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [15:0]        out_sequence;
    logic signed [31:0] out_check;
    logic [63:0]        out_payload_low;
    logic [63:0]        out_payload_middle;
    logic [31:0]        out_payload_high;
    logic               last;
  } res_t;

  // run of packets to read from the store, or a drop notice
  typedef struct packed {
    cmd_kind_e        kind;
    logic [SEQ_W-1:0] seq;
    logic [15:0]      slot;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic                 we;
    logic [15:0]          addr;
    logic [PAYLOAD_W-1:0] data;
  } mem_wr_t;

  function automatic logic [CNT_W-1:0] eff_window(logic [CNT_W-1:0] w);
    logic [CNT_W-1:0] r;
    if (w == '0) begin
      r = CNT_W'(1);
    end else if (w > CNT_W'(MAX_WINDOW)) begin
      r = CNT_W'(MAX_WINDOW);
    end else begin
      r = w;
    end
    return r;
  endfunction

  // sequence number plus signed payload bytes, two-level adder tree
  function automatic logic [CHK_W-1:0] check_of(logic [SEQ_W-1:0] seq,
                                                logic [PAYLOAD_W-1:0] data);
    logic signed [SUM_W-1:0] grp [GRP_NUM];
    logic signed [SUM_W-1:0] total;
    for (int g = 0; g < GRP_NUM; g++) begin
      grp[g] = '0;
      for (int b = 0; b < GRP_BYTES; b++) begin
        grp[g] = grp[g] + SUM_W'(signed'(data[(g * GRP_BYTES + b) * 8 +: 8]));
      end
    end
    total = '0;
    for (int g = 0; g < GRP_NUM; g++) begin
      total = total + grp[g];
    end
    return CHK_W'(seq) + CHK_W'(total);
  endfunction

endpackage

// ----- rtl/gbn_front.sv -----
module gbn_front #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  gbn_pkg::req_t                 req_i,
  input  logic                          cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          cmd_full_i,
  input  logic                          back_busy_i,
  output logic                          cmd_push_o,
  output gbn_pkg::cmd_t                 cmd_o,
  output gbn_pkg::mem_wr_t              mem_wr_o
);
  import gbn_pkg::*;

  localparam int unsigned SLOT_W = $clog2(STORE_DEPTH);
  localparam logic [16:0] DEPTH_17 = 17'(STORE_DEPTH);

  front_state_e state_q, state_d;
  req_t item_q;

  logic [CNT_W-1:0]  window_q;
  logic [15:0]       timeout_q;
  logic [SEQ_W-1:0]  base_q, base_d, nsend_q, nsend_d, nstore_q, nstore_d;
  logic [SLOT_W-1:0] base_slot_q, base_slot_d, send_slot_q, send_slot_d;
  logic [SLOT_W-1:0] store_slot_q, store_slot_d;
  logic              timer_run_q, timer_run_d;
  logic [15:0]       ticks_q, ticks_d;

  logic [SEQ_W-1:0] inflight, stored, avail, ack_dist, ack_next;
  logic [CNT_W-1:0] win, room, fill_cnt;
  logic [CHK_W-1:0] ack_sum;
  logic             store_full, ack_ok, ack_new;

  function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] s,
                                                 logic [CNT_W-1:0] k);
    logic [SLOT_W:0] t;
    t = {1'b0, s} + (SLOT_W + 1)'(k);
    if (t >= (SLOT_W + 1)'(STORE_DEPTH)) begin
      t = t - (SLOT_W + 1)'(STORE_DEPTH);
    end
    return t[SLOT_W-1:0];
  endfunction

  assign full_o = (state_q != F_IDLE);

  assign inflight   = nsend_q - base_q;
  assign stored     = nstore_q - base_q;
  assign avail      = nstore_q - nsend_q;
  assign store_full = (17'(stored) >= DEPTH_17) || (stored == 16'hFFFF);

  assign ack_sum  = CHK_W'(item_q.ack_number) + CHK_W'(item_q.ack_sequence);
  assign ack_ok   = ($unsigned(item_q.ack_check) == ack_sum);
  assign ack_dist = item_q.ack_number - base_q;
  assign ack_new  = (ack_dist < inflight);
  assign ack_next = item_q.ack_number + 16'd1;

  assign win      = eff_window(window_q);
  assign room     = (inflight >= SEQ_W'(win)) ? '0 : win - inflight[CNT_W-1:0];
  assign fill_cnt = (avail < SEQ_W'(room)) ? avail[CNT_W-1:0] : room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WINDOW_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW:  window_q  <= cfg_data_i[CNT_W-1:0];
        REG_TIMEOUT: timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      item_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      base_q       <= '0;
      nsend_q      <= '0;
      nstore_q     <= '0;
      base_slot_q  <= '0;
      send_slot_q  <= '0;
      store_slot_q <= '0;
      timer_run_q  <= 1'b0;
      ticks_q      <= '0;
    end else begin
      state_q      <= state_d;
      base_q       <= base_d;
      nsend_q      <= nsend_d;
      nstore_q     <= nstore_d;
      base_slot_q  <= base_slot_d;
      send_slot_q  <= send_slot_d;
      store_slot_q <= store_slot_d;
      timer_run_q  <= timer_run_d;
      ticks_q      <= ticks_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    base_d       = base_q;
    nsend_d      = nsend_q;
    nstore_d     = nstore_q;
    base_slot_d  = base_slot_q;
    send_slot_d  = send_slot_q;
    store_slot_d = store_slot_q;
    timer_run_d  = timer_run_q;
    ticks_d      = ticks_q;
    cmd_push_o   = 1'b0;
    cmd_o        = '{kind: CMD_SEND, seq: '0, slot: '0, count: '0};
    mem_wr_o.we   = 1'b0;
    mem_wr_o.addr = 16'(store_slot_q);
    mem_wr_o.data = {item_q.payload_high, item_q.payload_middle, item_q.payload_low};

    unique case (state_q)
      F_IDLE: begin
        if (push_i) begin
          state_d = F_EXEC;
        end
      end
      F_EXEC: begin
        unique case (item_q.req_type)
          REQ_MSG: begin
            // store write waits until no read of the store is pending
            if (!cmd_full_i && !back_busy_i) begin
              if (store_full) begin
                cmd_push_o = 1'b1;
                cmd_o.kind = CMD_DROP;
                state_d    = F_IDLE;
              end else begin
                mem_wr_o.we  = 1'b1;
                nstore_d     = nstore_q + 16'd1;
                store_slot_d = slot_add(store_slot_q, CNT_W'(1));
                state_d      = F_FILL;
              end
            end
          end
          REQ_ACK: begin
            state_d = F_IDLE;
            if (ack_ok) begin
              if (ack_new) begin
                base_slot_d = slot_add(base_slot_q,
                                       CNT_W'(ack_dist[CNT_W-2:0]) + CNT_W'(1));
                base_d      = ack_next;
                if (ack_next == nsend_q) begin
                  timer_run_d = 1'b0;
                  ticks_d     = '0;
                end else begin
                  timer_run_d = 1'b1;
                  ticks_d     = (timeout_q == '0) ? 16'd1 : timeout_q;
                end
                state_d = F_FILL;
              end
            end else begin
              // corrupt ack restarts the timer
              timer_run_d = 1'b1;
              ticks_d     = (timeout_q == '0) ? 16'd1 : timeout_q;
            end
          end
          REQ_TICK: begin
            if (!cmd_full_i) begin
              state_d = F_IDLE;
              if (timer_run_q) begin
                if (ticks_q <= 16'd1) begin
                  timer_run_d = 1'b1;
                  ticks_d     = (timeout_q == '0) ? 16'd1 : timeout_q;
                  if (inflight != '0) begin
                    cmd_push_o  = 1'b1;
                    cmd_o.seq   = base_q;
                    cmd_o.slot  = 16'(base_slot_q);
                    cmd_o.count = inflight[CNT_W-1:0];
                  end
                end else begin
                  ticks_d = ticks_q - 16'd1;
                end
              end
            end
          end
          default: state_d = F_IDLE;
        endcase
      end
      F_FILL: begin
        if (!cmd_full_i) begin
          state_d = F_IDLE;
          if (fill_cnt != '0) begin
            cmd_push_o  = 1'b1;
            cmd_o.seq   = nsend_q;
            cmd_o.slot  = 16'(send_slot_q);
            cmd_o.count = fill_cnt;
            if (inflight == '0) begin
              timer_run_d = 1'b1;
              ticks_d     = (timeout_q == '0) ? 16'd1 : timeout_q;
            end
            nsend_d     = nsend_q + SEQ_W'(fill_cnt);
            send_slot_d = slot_add(send_slot_q, fill_cnt);
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_inflight_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight <= SEQ_W'(MAX_WINDOW))
    else $error("more packets in flight than the largest window");

  a_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    17'(stored) <= DEPTH_17)
    else $error("store holds more messages than its depth");

  a_pointer_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight <= stored)
    else $error("send pointer passed store pointer");

  a_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_o.we |-> !back_busy_i && !cmd_full_i)
    else $error("store written while a read run is pending");
`endif

endmodule

// ----- rtl/gbn_cmd_queue.sv -----
module gbn_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gbn_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output gbn_pkg::cmd_t cmd_o,
  output logic          empty_o
);
  import gbn_pkg::*;

  cmd_t                 entry_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_PTR_W:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == (CMD_PTR_W + 1)'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
      end
      cnt_q <= cnt_q + (CMD_PTR_W + 1)'(do_push) - (CMD_PTR_W + 1)'(do_pop);
    end
  end

endmodule

// ----- rtl/gbn_back.sv -----
module gbn_back #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_empty_i,
  input  gbn_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  gbn_pkg::mem_wr_t mem_wr_i,
  output logic             busy_o,
  output gbn_pkg::res_t    res_o,
  output logic             empty_o,
  input  logic             pop_i
);
  import gbn_pkg::*;

  localparam int unsigned SLOT_W = $clog2(STORE_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(STORE_DEPTH - 1);

  logic [PAYLOAD_W-1:0] store_mem [STORE_DEPTH];
  logic [PAYLOAD_W-1:0] mem_q;
  logic                 rd_en;

  logic              active_q, active_d;
  logic [SEQ_W-1:0]  cur_seq_q, cur_seq_d;
  logic [SLOT_W-1:0] cur_slot_q, cur_slot_d;
  logic [CNT_W-1:0]  left_q, left_d;

  logic             s1_v_q, s1_v_d;
  logic             s1_drop_q, s1_drop_d, s1_last_q, s1_last_d;
  logic [SEQ_W-1:0] s1_seq_q, s1_seq_d;

  res_t                 out_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_PTR_W:0]   out_cnt_q;
  logic [OUT_PTR_W+1:0] committed;
  logic                 room, do_pop;
  res_t                 res_w;

  // count the result still in the read stage against the free slots
  assign committed = (OUT_PTR_W + 2)'(out_cnt_q) + (OUT_PTR_W + 2)'(s1_v_q);
  assign room      = (committed < (OUT_PTR_W + 2)'(OUT_DEPTH));
  assign busy_o    = active_q || !cmd_empty_i;
  assign empty_o   = (out_cnt_q == '0);
  assign do_pop    = pop_i && !empty_o;
  assign res_o     = out_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.we) begin
      store_mem[mem_wr_i.addr[SLOT_W-1:0]] <= mem_wr_i.data;
    end
    if (rd_en) begin
      mem_q <= store_mem[cur_slot_q];
    end
  end

  always_comb begin
    rd_en      = 1'b0;
    cmd_pop_o  = 1'b0;
    active_d   = active_q;
    cur_seq_d  = cur_seq_q;
    cur_slot_d = cur_slot_q;
    left_d     = left_q;
    s1_v_d     = 1'b0;
    s1_drop_d  = 1'b0;
    s1_last_d  = 1'b0;
    s1_seq_d   = cur_seq_q;
    if (room) begin
      if (active_q) begin
        rd_en      = 1'b1;
        s1_v_d     = 1'b1;
        s1_last_d  = (left_q == CNT_W'(1));
        cur_seq_d  = cur_seq_q + 16'd1;
        cur_slot_d = (cur_slot_q == SLOT_LAST) ? '0 : cur_slot_q + SLOT_W'(1);
        left_d     = left_q - CNT_W'(1);
        if (left_q == CNT_W'(1)) begin
          active_d = 1'b0;
        end
      end else if (!cmd_empty_i) begin
        cmd_pop_o = 1'b1;
        if (cmd_i.kind == CMD_DROP) begin
          s1_v_d    = 1'b1;
          s1_drop_d = 1'b1;
          s1_last_d = 1'b1;
        end else begin
          active_d   = 1'b1;
          cur_seq_d  = cmd_i.seq;
          cur_slot_d = cmd_i.slot[SLOT_W-1:0];
          left_d     = cmd_i.count;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      s1_v_q   <= 1'b0;
      left_q   <= '0;
    end else begin
      active_q <= active_d;
      s1_v_q   <= s1_v_d;
      left_q   <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_seq_q  <= cur_seq_d;
    cur_slot_q <= cur_slot_d;
    s1_drop_q  <= s1_drop_d;
    s1_last_q  <= s1_last_d;
    s1_seq_q   <= s1_seq_d;
  end

  always_comb begin
    if (s1_drop_q) begin
      res_w        = '0;
      res_w.status = 1'b1;
      res_w.last   = 1'b1;
    end else begin
      res_w.status             = 1'b0;
      res_w.out_sequence       = s1_seq_q;
      res_w.out_check          = signed'(check_of(s1_seq_q, mem_q));
      res_w.out_payload_low    = mem_q[63:0];
      res_w.out_payload_middle = mem_q[127:64];
      res_w.out_payload_high   = mem_q[159:128];
      res_w.last               = s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      out_q[wr_ptr_q] <= res_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (s1_v_q) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
      out_cnt_q <= out_cnt_q + (OUT_PTR_W + 1)'(s1_v_q) - (OUT_PTR_W + 1)'(do_pop);
    end
  end

`ifndef ASSERT_OFF
  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> out_cnt_q < (OUT_PTR_W + 1)'(OUT_DEPTH))
    else $error("result queue written while full");

  a_active_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> left_q != '0)
    else $error("read run active with nothing left");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_last_q) |-> active_q)
    else $error("read run ended before its last packet");
`endif

endmodule

// ----- rtl/go_back_n_sender.sv -----
// go-back-n sender: a drop notice, a packet sent from a message or ack and a
// resend after a timeout each pass the front, the command queue and the back
// a request holds the front in exec alone (tick, drop, bad or stale ack) or in exec
// and fill (stored message, accepted ack); a message also waits for earlier read runs
// runs leave at one packet per cycle while results have room (single store read port)
// reset is asynchronous active low: pointers, timer and queues clear, not the store
module go_back_n_sender #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request side
  input  logic                           push,
  output logic                           full,
  input  gbn_pkg::req_t                  req_i,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // result side
  output logic                           empty,
  input  logic                           pop,
  output gbn_pkg::res_t                  res_o
);
  import gbn_pkg::*;

  // front to back command path
  logic    cmd_push, cmd_full, cmd_pop, cmd_empty, back_busy;
  cmd_t    cmd_in, cmd_out;
  mem_wr_t mem_wr;

  // front: holds one request, keeps window pointers and the timer,
  // writes new messages to the store and posts read runs and drop notices
  gbn_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_full_i  (cmd_full),
    .back_busy_i (back_busy),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .mem_wr_o    (mem_wr)
  );

  // short queue of read runs and drop notices
  gbn_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_out),
    .empty_o (cmd_empty)
  );

  // back: owns the store, reads one packet per cycle while results have room,
  // adds the checksum and queues results for the consumer
  gbn_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .mem_wr_i    (mem_wr),
    .busy_o      (back_busy),
    .res_o       (res_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import gbn_pkg::*;

  localparam int unsigned STORE_DEPTH   = 1024;
  // one request never yields more packets than this
  localparam int unsigned MAX_BURST     = 64;
  // quiet cycles after the last packet before touching registers
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned LIMIT_CYCLES  = 6_000_000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 50;
  // messages buffered behind a shut window
  localparam int unsigned FILL_ITEMS    = 80;
  // receiver hold-off and the messages offered meanwhile
  localparam int unsigned STALL_CYCLES  = 400;
  localparam int unsigned STALL_ITEMS   = 10;

  // request kind the block must ignore, register index with no register
  localparam logic [1:0]           REQ_NONE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic STATUS_SENT    = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  // one buffered message
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] mid;
    logic [31:0] hi;
  } msg_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  req_t                  req_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  empty;
  logic                  pop;
  res_t                  res_o;

  go_back_n_sender #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_o)
  );

  // own copy of the sender state, predicts the packets of each request
  class gbn_scoreboard;
    msg_t        msg_store [STORE_DEPTH];
    int unsigned base_slot;
    logic [15:0] base_seq;
    logic [15:0] send_seq;
    logic [15:0] store_seq;
    logic [15:0] ticks_left;
    bit          timer_on;
    logic [6:0]  window_reg;
    logic [15:0] timeout_reg;
    res_t        expected_packets [$];
    res_t        burst [$];
    int          mismatches;

    function new();
      base_slot   = 0;
      base_seq    = '0;
      send_seq    = '0;
      store_seq   = '0;
      ticks_left  = '0;
      timer_on    = 1'b0;
      window_reg  = WINDOW_RESET;
      timeout_reg = TIMEOUT_RESET;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WINDOW:  window_reg = data[6:0];
        REG_TIMEOUT: timeout_reg = data;
        default: ;
      endcase
    endfunction

    function int unsigned window_limit();
      if (window_reg == '0) return 1;
      if (window_reg > MAX_WINDOW) return MAX_WINDOW;
      return window_reg;
    endfunction

    function void restart_timer();
      timer_on   = 1'b1;
      ticks_left = (timeout_reg == '0) ? 16'd1 : timeout_reg;
    endfunction

    function int unsigned slot_of(logic [15:0] seq);
      logic [15:0] off;
      off = seq - base_seq;
      return (base_slot + off) % STORE_DEPTH;
    endfunction

    function void emit_packet(logic [15:0] seq);
      msg_t                 m;
      logic [PAYLOAD_W-1:0] flat;
      byte                  b;
      int                   sum;
      res_t                 p;
      m    = msg_store[slot_of(seq)];
      flat = {m.hi, m.mid, m.lo};
      sum  = 0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        b = flat[8*i +: 8];
        sum += b;
      end
      p                    = '0;
      p.status             = STATUS_SENT;
      p.out_sequence       = seq;
      p.out_check          = 32'(seq) + sum;
      p.out_payload_low    = m.lo;
      p.out_payload_middle = m.mid;
      p.out_payload_high   = m.hi;
      burst.push_back(p);
    endfunction

    // send buffered messages while the window has room
    function void fill_window();
      logic [15:0] in_flight;
      while (burst.size() < MAX_BURST && send_seq != store_seq) begin
        in_flight = send_seq - base_seq;
        if (in_flight >= window_limit()) break;
        if (in_flight == '0) restart_timer();
        emit_packet(send_seq);
        send_seq++;
      end
    endfunction

    function void note_request(req_t r);
      logic [15:0] stored;
      logic [15:0] ack_gap;
      logic [15:0] in_flight;
      logic [15:0] s;
      res_t        p;
      burst.delete();
      case (r.req_type)
        REQ_MSG: begin
          stored = store_seq - base_seq;
          if (stored >= STORE_DEPTH || stored >= 16'hFFFF) begin
            // store full, message dropped
            p        = '0;
            p.status = STATUS_DROPPED;
            burst.push_back(p);
          end else begin
            msg_store[slot_of(store_seq)] = {r.payload_low, r.payload_middle, r.payload_high};
            store_seq++;
            fill_window();
          end
        end
        REQ_ACK: begin
          if ((32'(r.ack_number) + 32'(r.ack_sequence)) == $unsigned(r.ack_check)) begin
            ack_gap   = r.ack_number - base_seq;
            in_flight = send_seq - base_seq;
            // stale acks fall through untouched
            if (ack_gap < in_flight) begin
              base_slot = (base_slot + ack_gap + 1) % STORE_DEPTH;
              base_seq  = r.ack_number + 16'd1;
              if (base_seq == send_seq) begin
                timer_on   = 1'b0;
                ticks_left = '0;
              end else begin
                restart_timer();
              end
              fill_window();
            end
          end else begin
            restart_timer();
          end
        end
        REQ_TICK: begin
          if (timer_on) begin
            if (ticks_left <= 16'd1) begin
              restart_timer();
              s = base_seq;
              while (s != send_seq && burst.size() < MAX_BURST) begin
                emit_packet(s);
                s++;
              end
            end else begin
              ticks_left--;
            end
          end
        end
        default: ;
      endcase
      foreach (burst[i]) begin
        p      = burst[i];
        p.last = (i == burst.size() - 1);
        expected_packets.push_back(p);
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_packet(res_t got);
      res_t want;
      if (expected_packets.size() == 0) begin
        $display("%0t: unexpected packet, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_packets.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("out_sequence", want.out_sequence, got.out_sequence);
      compare_field("out_check", want.out_check, got.out_check);
      compare_field("out_payload_low", want.out_payload_low, got.out_payload_low);
      compare_field("out_payload_middle", want.out_payload_middle, got.out_payload_middle);
      compare_field("out_payload_high", want.out_payload_high, got.out_payload_high);
      compare_field("last", want.last, got.last);
    endfunction

    function int pending();
      return expected_packets.size();
    endfunction
  endclass

  gbn_scoreboard sb;
  int            tx_gap_max;
  int            rx_gap_max;
  // long receiver hold-off, picked up by the result sink
  int            stall_len;
  int unsigned   cycle_count;

  function automatic int draw_gap(int max_gap);
    return (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
  endfunction

  // every field random, callers then shape the kind
  function automatic req_t rand_req();
    req_t r;
    r.req_type       = 2'($urandom);
    r.payload_low    = {$urandom, $urandom};
    r.payload_middle = {$urandom, $urandom};
    r.payload_high   = $urandom;
    r.ack_number     = 16'($urandom);
    r.ack_sequence   = 16'($urandom);
    r.ack_check      = $urandom;
    return r;
  endfunction

  function automatic req_t pattern_msg(logic [7:0] b);
    req_t r;
    r = rand_req();
    r.req_type = REQ_MSG;
    {r.payload_high, r.payload_middle, r.payload_low} = {20{b}};
    return r;
  endfunction

  function automatic req_t msg_req();
    req_t r;
    r = rand_req();
    r.req_type = REQ_MSG;
    // now and then a payload of extreme bytes
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       r = pattern_msg(8'h00);
        1:       r = pattern_msg(8'hFF);
        2:       r = pattern_msg(8'h80);
        default: r = pattern_msg(8'h7F);
      endcase
    end
    return r;
  endfunction

  function automatic req_t valid_ack(logic [15:0] n);
    req_t r;
    r = rand_req();
    r.req_type   = REQ_ACK;
    r.ack_number = n;
    r.ack_check  = 32'(n) + 32'(r.ack_sequence);
    return r;
  endfunction

  // one flipped bit keeps the checksum wrong
  function automatic req_t corrupt_ack();
    req_t r;
    r = rand_req();
    r.req_type  = REQ_ACK;
    r.ack_check = (32'(r.ack_number) + 32'(r.ack_sequence)) ^ (32'd1 << $urandom_range(0, 31));
    return r;
  endfunction

  function automatic req_t tick_req();
    req_t r;
    r = rand_req();
    r.req_type = REQ_TICK;
    return r;
  endfunction

  // offer one request after a random gap, return once it is taken
  task automatic send_req(input req_t r);
    int gap;
    gap = draw_gap(tx_gap_max);
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push  <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_request(r);
  endtask

  // sender pauses until every predicted packet has come out
  task automatic wait_for_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // idle point: also lets an ack or tick with no packets finish inside the block
  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // mostly messages and good acks, some ticks, bad acks and junk
  task automatic random_request();
    int          k;
    logic [15:0] in_flight;
    req_t        r;
    k         = $urandom_range(0, 99);
    in_flight = sb.send_seq - sb.base_seq;
    if (k < 40) begin
      r = msg_req();
    end else if (k < 65 && in_flight != '0) begin
      r = valid_ack(sb.base_seq + 16'($urandom_range(0, in_flight - 1)));
    end else if (k < 85) begin
      r = tick_req();
    end else if (k < 90) begin
      r = corrupt_ack();
    end else if (k < 95) begin
      // well-formed ack beyond what is in flight
      r = valid_ack(sb.send_seq + 16'($urandom_range(0, 200)));
    end else begin
      r = rand_req();
      r.req_type = REQ_NONE;
    end
    send_req(r);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("go_back_n_sender regression: fail");
      $finish;
    end
  end

  // every popped packet goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_packet(res_o);
  end

  // result sink: random wait before each packet, or the long hold-off
  initial begin : result_sink
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      if (stall_len > 0) begin
        gap       = stall_len;
        stall_len = 0;
      end else begin
        gap = draw_gap(rx_gap_max);
      end
      if (gap > 0) begin
        @(negedge clk_i);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    req_t        r;
    logic [6:0]  w;
    push        = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    pop         = 1'b0;
    rst_ni      = 1'b0;
    cycle_count = 0;
    stall_len   = 0;
    tx_gap_max  = 19;
    rx_gap_max  = 19;
    sb          = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: extreme payload bytes, junk kind, bad, stale and good acks
    send_req(pattern_msg(8'h00));
    send_req(pattern_msg(8'hFF));
    send_req(pattern_msg(8'h80));
    send_req(pattern_msg(8'h7F));
    r = rand_req();
    r.req_type = REQ_NONE;
    send_req(r);
    r = valid_ack(16'd0);
    r.ack_check = 32'h8000_0000;
    send_req(r);
    r = valid_ack(16'hFFFF);
    r.ack_sequence = 16'hFFFF;
    r.ack_check    = 32'h0001_FFFE;
    send_req(r);
    send_req(valid_ack(sb.base_seq + 16'd1));
    settle();

    // window zero acts as one, timeout zero acts as one
    write_cfg(REG_WINDOW, 16'hFF80);
    write_cfg(REG_TIMEOUT, 16'h0000);
    write_cfg(REG_UNUSED, 16'($urandom));
    send_req(msg_req());
    send_req(corrupt_ack());
    send_req(tick_req());
    send_req(valid_ack(sb.send_seq - 16'd1));
    send_req(tick_req());
    send_req(valid_ack(sb.send_seq - 16'd1));
    // timer stopped, then started by a bad ack with nothing in flight
    send_req(tick_req());
    send_req(corrupt_ack());
    send_req(tick_req());
    send_req(msg_req());
    settle();

    // window above the cap, longest timeout
    write_cfg(REG_WINDOW, 16'd127);
    write_cfg(REG_TIMEOUT, 16'hFFFF);
    repeat (3) send_req(msg_req());
    send_req(valid_ack(sb.base_seq + 16'd1));
    send_req(tick_req());
    settle();

    // buffer messages with the window shut
    write_cfg(REG_WINDOW, 16'd1);
    repeat (FILL_ITEMS) send_req(msg_req());
    settle();

    // drain in full windows while the receiver holds off, then keep offering
    // messages so the input stalls behind the blocked result path
    write_cfg(REG_WINDOW, 16'd64);
    stall_len = STALL_CYCLES;
    while (sb.base_seq != sb.store_seq) send_req(valid_ack(sb.send_seq - 16'd1));
    repeat (STALL_ITEMS) send_req(msg_req());
    settle();

    // random phases, each under its own settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       w = 7'd1;
        1:       w = 7'd64;
        2:       w = 7'd127;
        4:       w = 7'd0;
        default: w = 7'($urandom_range(2, 63));
      endcase
      write_cfg(REG_WINDOW, {9'($urandom), w});
      write_cfg(REG_TIMEOUT, (p == 2) ? 16'd0 : 16'($urandom_range(1, 6)));
      tx_gap_max = (p % 2 == 0) ? 19 : 0;
      rx_gap_max = (p % 3 == 1) ? 0 : 19;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 49) == 0) wait_for_results();
        random_request();
      end
      settle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("go_back_n_sender regression: pass");
    end else begin
      $display("go_back_n_sender regression: fail");
    end
    $finish;
  end

endmodule
